### src/spcir_pkg.sv
// Package for the sense-plate command parser and IR vote block.
// Operation and mode codes, command bytes, reset values and the result record.
// No dependencies.
package spcir_pkg;

  localparam int SAMPLE_BITS_DEF    = 10;
  localparam int TOUCH_CHANNELS_DEF = 3;

  // width of the sense state returned on a read
  localparam int SENSE_W = 3;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_STOP  = 3'd2,
    OP_ERROR = 3'd3,
    OP_IR    = 3'd4,
    OP_TOUCH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_IR    = 2'd1,
    MODE_TOUCH = 2'd2
  } mode_t;

  localparam logic [7:0] CMD_RECAL_TOUCH = 8'h10;
  localparam logic [7:0] CMD_SET_THRESH  = 8'h81;
  localparam logic [7:0] CMD_SET_ROUND   = 8'h82;
  localparam logic [7:0] CMD_SET_DELAY   = 8'h83;
  localparam logic [7:0] CMD_SET_AGAIN   = 8'h8A;
  localparam logic [7:0] CMD_SET_DGAIN   = 8'h8B;
  localparam logic [7:0] CMD_SET_FILTER  = 8'h8C;
  localparam logic [7:0] CMD_MODE_IR     = 8'hF0;
  localparam logic [7:0] CMD_MODE_TOUCH  = 8'hF1;
  localparam logic [7:0] CMD_START       = 8'hFA;
  localparam logic [7:0] CMD_RESET       = 8'hFB;

  localparam logic [7:0] IR_THRESH_RST = 8'd20;
  localparam logic [7:0] IR_ROUND_RST  = 8'd10;

  typedef struct packed {
    logic [SENSE_W-1:0] read_data;
    logic               trigger_line;
    logic [1:0]         run_mode;
    logic               started;
    logic               touch_apply;
    logic               touch_recalibrate;
    logic               reset_request;
    logic [7:0]         touch_analog_gain;
    logic [7:0]         touch_digital_gain;
    logic [7:0]         touch_filter_level;
    logic [7:0]         ir_delay_ms;
  } res_t;

endpackage

### src/sense_plate_command_and_ir_vote.sv
// Sense-plate command parser with IR round vote and touch flags.
// Depends on spcir_pkg.
//
// Usage: one input channel (in_valid/in_stall) carries bus events (write byte,
// read, stop, error) and sensor events (IR off/on sample pair, touch bits).
// Every accepted input transfer yields exactly one result transfer on the
// out_ channel carrying read data, trigger line level, run mode, started
// flag, the three command pulses and the stored gain, filter and delay settings.
// A result is registered in the output register, or in the skid entry while the receiver stalls.
// Throughput is one item per cycle while in_stall is low; all the work of an item
// is a single pass of register updates, so consecutive items may arrive every cycle.
// The result side has an output register plus one skid entry. When the
// receiver stalls, one more input is taken into the skid entry; after that
// in_stall rises until the output register drains. No result is dropped.
// Reset (rst_n low, synchronous) returns all parser, setting and vote state
// to its reset values and empties the output side. The software reset
// command does the same to the block state and reports it with a pulse.
module sense_plate_command_and_ir_vote
  import spcir_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int TOUCH_CHANNELS = TOUCH_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_operation,
  input  logic [7:0]                in_bus_byte,
  input  logic [SAMPLE_BITS-1:0]    in_ir_off_sample,
  input  logic [SAMPLE_BITS-1:0]    in_ir_on_sample,
  input  logic [TOUCH_CHANNELS-1:0] in_touch_bits,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SENSE_W-1:0]        out_read_data,
  output logic                      out_trigger_line,
  output logic [1:0]                out_run_mode,
  output logic                      out_started,
  output logic                      out_touch_apply,
  output logic                      out_touch_recalibrate,
  output logic                      out_reset_request,
  output logic [7:0]                out_touch_analog_gain,
  output logic [7:0]                out_touch_digital_gain,
  output logic [7:0]                out_touch_filter_level,
  output logic [7:0]                out_ir_delay_ms
);

  localparam int TW = (TOUCH_CHANNELS > SENSE_W) ? TOUCH_CHANNELS : SENSE_W;

  // block state
  logic               awaiting_r, awaiting_nxt;
  logic [7:0]         held_cmd_r, held_cmd_nxt;
  logic [7:0]         thresh_r, thresh_nxt;
  logic [7:0]         round_r, round_nxt;
  logic [7:0]         pause_r, pause_nxt;
  logic [7:0]         again_r, again_nxt;
  logic [7:0]         dgain_r, dgain_nxt;
  logic [7:0]         filter_r, filter_nxt;
  mode_t              mode_r, mode_nxt;
  logic               running_r, running_nxt;
  logic [7:0]         hits_r, hits_nxt;
  logic [7:0]         taken_r, taken_nxt;
  logic               ir_flag_r, ir_flag_nxt;
  logic [SENSE_W-1:0] touch_r, touch_nxt;
  logic [SENSE_W-1:0] sense_r, sense_nxt;
  logic               pending_r, pending_nxt;
  logic               line_r, line_nxt;

  // output side
  logic               out_valid_r;
  logic               skid_valid_r;
  res_t               out_r, skid_r, res;

  logic               accept;
  op_t                op;
  logic [TW-1:0]      touch_ext;
  logic [SAMPLE_BITS-1:0] diff;
  logic               hit;
  logic [7:0]         hits_inc, taken_inc;
  logic [SENSE_W-1:0] sense_val;
  logic               sense_upd;
  logic               rd_en, apply, recal, soft_rst;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(in_operation);

  assign touch_ext = TW'(in_touch_bits);
  assign diff      = (in_ir_on_sample >= in_ir_off_sample) ?
                     (in_ir_on_sample - in_ir_off_sample) :
                     (in_ir_off_sample - in_ir_on_sample);
  assign hit       = diff >= SAMPLE_BITS'(thresh_r);
  assign hits_inc  = hits_r + 8'(hit);
  assign taken_inc = taken_r + 8'd1;

  always_comb begin
    awaiting_nxt = awaiting_r;
    held_cmd_nxt = held_cmd_r;
    thresh_nxt   = thresh_r;
    round_nxt    = round_r;
    pause_nxt    = pause_r;
    again_nxt    = again_r;
    dgain_nxt    = dgain_r;
    filter_nxt   = filter_r;
    mode_nxt     = mode_r;
    running_nxt  = running_r;
    hits_nxt     = hits_r;
    taken_nxt    = taken_r;
    ir_flag_nxt  = ir_flag_r;
    touch_nxt    = touch_r;
    pending_nxt  = pending_r;
    line_nxt     = line_r;
    rd_en        = 1'b0;
    apply        = 1'b0;
    recal        = 1'b0;
    soft_rst     = 1'b0;
    sense_upd    = 1'b0;

    unique case (op)
      OP_WRITE: begin
        if (!awaiting_r) begin
          held_cmd_nxt = in_bus_byte;
          case (in_bus_byte) inside
            CMD_MODE_IR: begin
              mode_nxt  = MODE_IR;
              hits_nxt  = '0;
              taken_nxt = '0;
            end
            CMD_MODE_TOUCH: begin
              mode_nxt = MODE_TOUCH;
              apply    = 1'b1;
            end
            CMD_RECAL_TOUCH: recal = 1'b1;
            CMD_START:       running_nxt = 1'b1;
            CMD_RESET:       soft_rst = 1'b1;
            CMD_SET_THRESH, CMD_SET_ROUND, CMD_SET_DELAY,
            CMD_SET_AGAIN, CMD_SET_DGAIN, CMD_SET_FILTER: awaiting_nxt = 1'b1;
            default: ;
          endcase
        end else begin
          unique case (held_cmd_r)
            CMD_SET_THRESH: thresh_nxt = in_bus_byte;
            CMD_SET_ROUND:  round_nxt  = in_bus_byte;
            CMD_SET_DELAY:  pause_nxt  = in_bus_byte;
            CMD_SET_AGAIN:  again_nxt  = in_bus_byte;
            CMD_SET_DGAIN:  dgain_nxt  = in_bus_byte;
            CMD_SET_FILTER: filter_nxt = in_bus_byte;
            default: ;
          endcase
          awaiting_nxt = 1'b0;
        end
      end
      OP_READ: begin
        rd_en       = 1'b1;
        pending_nxt = 1'b0;
        line_nxt    = 1'b0;
      end
      OP_STOP:  awaiting_nxt = 1'b0;
      OP_ERROR: begin
        awaiting_nxt = 1'b0;
        line_nxt     = 1'b0;
      end
      OP_IR: begin
        if (running_r && mode_r == MODE_IR && !pending_r) begin
          sense_upd = 1'b1;
          if (round_r == 8'd0) begin
            hits_nxt    = '0;
            taken_nxt   = '0;
            ir_flag_nxt = 1'b0;
          end else if (taken_inc >= round_r) begin
            // round over: pass when at least half the samples hit
            ir_flag_nxt = {hits_inc, 1'b0} >= {1'b0, round_r};
            hits_nxt    = '0;
            taken_nxt   = '0;
          end else begin
            hits_nxt  = hits_inc;
            taken_nxt = taken_inc;
          end
        end
      end
      OP_TOUCH: begin
        if (running_r && mode_r == MODE_TOUCH && !pending_r) begin
          sense_upd = 1'b1;
          touch_nxt = touch_ext[SENSE_W-1:0];
        end
      end
      default: ;
    endcase

    sense_val = touch_nxt | SENSE_W'(ir_flag_nxt);
    sense_nxt = sense_r;
    if (sense_upd && sense_val != sense_r) begin
      sense_nxt   = sense_val;
      line_nxt    = 1'b1;
      pending_nxt = 1'b1;
    end

    if (soft_rst) begin
      awaiting_nxt = 1'b0;
      held_cmd_nxt = '0;
      thresh_nxt   = IR_THRESH_RST;
      round_nxt    = IR_ROUND_RST;
      pause_nxt    = '0;
      again_nxt    = '0;
      dgain_nxt    = '0;
      filter_nxt   = '0;
      mode_nxt     = MODE_HOLD;
      running_nxt  = 1'b0;
      hits_nxt     = '0;
      taken_nxt    = '0;
      ir_flag_nxt  = 1'b0;
      touch_nxt    = '0;
      sense_nxt    = '0;
      pending_nxt  = 1'b0;
      line_nxt     = 1'b0;
    end

    res.read_data          = rd_en ? sense_r : '0;
    res.trigger_line       = line_nxt;
    res.run_mode           = mode_nxt;
    res.started            = running_nxt;
    res.touch_apply        = apply;
    res.touch_recalibrate  = recal;
    res.reset_request      = soft_rst;
    res.touch_analog_gain  = again_nxt;
    res.touch_digital_gain = dgain_nxt;
    res.touch_filter_level = filter_nxt;
    res.ir_delay_ms        = pause_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      held_cmd_r <= '0;
      thresh_r   <= IR_THRESH_RST;
      round_r    <= IR_ROUND_RST;
      pause_r    <= '0;
      again_r    <= '0;
      dgain_r    <= '0;
      filter_r   <= '0;
      mode_r     <= MODE_HOLD;
      running_r  <= 1'b0;
      hits_r     <= '0;
      taken_r    <= '0;
      ir_flag_r  <= 1'b0;
      touch_r    <= '0;
      sense_r    <= '0;
      pending_r  <= 1'b0;
      line_r     <= 1'b0;
    end else if (accept) begin
      awaiting_r <= awaiting_nxt;
      held_cmd_r <= held_cmd_nxt;
      thresh_r   <= thresh_nxt;
      round_r    <= round_nxt;
      pause_r    <= pause_nxt;
      again_r    <= again_nxt;
      dgain_r    <= dgain_nxt;
      filter_r   <= filter_nxt;
      mode_r     <= mode_nxt;
      running_r  <= running_nxt;
      hits_r     <= hits_nxt;
      taken_r    <= taken_nxt;
      ir_flag_r  <= ir_flag_nxt;
      touch_r    <= touch_nxt;
      sense_r    <= sense_nxt;
      pending_r  <= pending_nxt;
      line_r     <= line_nxt;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (accept) begin
        skid_r <= res;
      end
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_read_data          = out_r.read_data;
  assign out_trigger_line       = out_r.trigger_line;
  assign out_run_mode           = out_r.run_mode;
  assign out_started            = out_r.started;
  assign out_touch_apply        = out_r.touch_apply;
  assign out_touch_recalibrate  = out_r.touch_recalibrate;
  assign out_reset_request      = out_r.reset_request;
  assign out_touch_analog_gain  = out_r.touch_analog_gain;
  assign out_touch_digital_gain = out_r.touch_digital_gain;
  assign out_touch_filter_level = out_r.touch_filter_level;
  assign out_ir_delay_ms        = out_r.ir_delay_ms;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_reset_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.reset_request |->
      !out_r.trigger_line && !out_r.started && out_r.run_mode == MODE_HOLD)
    else $error("software reset result does not show reset state");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_READ |=> !pending_r && !line_r)
    else $error("bus read did not clear pending change");

  a_apply_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.touch_apply |-> out_r.run_mode == MODE_TOUCH)
    else $error("touch apply pulse outside touch mode");

endmodule

### tb/sense_plate_command_and_ir_vote_checker.sv
// Checker for the sense-plate command parser: tracks accepted input transfers,
// predicts one result per transfer and compares the result channel field by field.
// Depends on spcir_pkg.
`timescale 1ns / 100ps

module sense_plate_command_and_ir_vote_checker
  import spcir_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic [7:0]                    in_bus_byte,
  input  logic [SAMPLE_BITS_DEF-1:0]    in_ir_off_sample,
  input  logic [SAMPLE_BITS_DEF-1:0]    in_ir_on_sample,
  input  logic [TOUCH_CHANNELS_DEF-1:0] in_touch_bits,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [SENSE_W-1:0]            out_read_data,
  input  logic                          out_trigger_line,
  input  logic [1:0]                    out_run_mode,
  input  logic                          out_started,
  input  logic                          out_touch_apply,
  input  logic                          out_touch_recalibrate,
  input  logic                          out_reset_request,
  input  logic [7:0]                    out_touch_analog_gain,
  input  logic [7:0]                    out_touch_digital_gain,
  input  logic [7:0]                    out_touch_filter_level,
  input  logic [7:0]                    out_ir_delay_ms,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_seen,
  output int                            sense_changes,
  output int                            ir_rounds
);

  // predicted device state
  logic         want_data;
  logic [7:0]   cmd_held;
  logic [7:0]   thresh;
  logic [7:0]   round_len;
  logic [7:0]   pause_ms;
  logic [7:0]   a_gain;
  logic [7:0]   d_gain;
  logic [7:0]   filt;
  mode_t        mode;
  logic         is_running;
  logic [7:0]   hit_cnt;
  logic [7:0]   pair_cnt;
  logic         vote_flag;
  logic [2:0]   touched;
  logic [2:0]   sense;
  logic         unread;
  logic         irq;

  res_t         pending_results[$];
  res_t         got;
  res_t         want;

  function void plate_reset();
    want_data  = 1'b0;
    cmd_held   = 8'h00;
    thresh     = IR_THRESH_RST;
    round_len  = IR_ROUND_RST;
    pause_ms   = 8'h00;
    a_gain     = 8'h00;
    d_gain     = 8'h00;
    filt       = 8'h00;
    mode       = MODE_HOLD;
    is_running = 1'b0;
    hit_cnt    = 8'h00;
    pair_cnt   = 8'h00;
    vote_flag  = 1'b0;
    touched    = 3'b000;
    sense      = 3'b000;
    unread     = 1'b0;
    irq        = 1'b0;
  endfunction

  function void sense_update();
    logic [2:0] v;
    v = touched | {2'b00, vote_flag};
    if (v != sense) begin
      sense = v;
      irq = 1'b1;
      unread = 1'b1;
      sense_changes++;
    end
  endfunction

  function automatic res_t plate_step(input logic [2:0] op, input logic [7:0] bv,
                                      input logic [SAMPLE_BITS_DEF-1:0] off_s,
                                      input logic [SAMPLE_BITS_DEF-1:0] on_s,
                                      input logic [2:0] tbits);
    res_t r;
    logic [SAMPLE_BITS_DEF-1:0] diff;
    r = '0;
    case (op)
      OP_WRITE: begin
        if (!want_data) begin
          cmd_held = bv;
          case (bv)
            CMD_MODE_IR: begin
              mode = MODE_IR;
              hit_cnt = 8'h00;
              pair_cnt = 8'h00;
            end
            CMD_MODE_TOUCH: begin
              mode = MODE_TOUCH;
              r.touch_apply = 1'b1;
            end
            CMD_RECAL_TOUCH: r.touch_recalibrate = 1'b1;
            CMD_START: is_running = 1'b1;
            CMD_RESET: begin
              plate_reset();
              r.reset_request = 1'b1;
            end
            CMD_SET_THRESH, CMD_SET_ROUND, CMD_SET_DELAY,
            CMD_SET_AGAIN, CMD_SET_DGAIN, CMD_SET_FILTER: want_data = 1'b1;
            default: ;
          endcase
        end else begin
          case (cmd_held)
            CMD_SET_THRESH: thresh = bv;
            CMD_SET_ROUND:  round_len = bv;
            CMD_SET_DELAY:  pause_ms = bv;
            CMD_SET_AGAIN:  a_gain = bv;
            CMD_SET_DGAIN:  d_gain = bv;
            CMD_SET_FILTER: filt = bv;
            default: ;
          endcase
          want_data = 1'b0;
        end
      end
      OP_READ: begin
        r.read_data = sense;
        unread = 1'b0;
        irq = 1'b0;
      end
      OP_STOP: want_data = 1'b0;
      OP_ERROR: begin
        // line drops but the unread flag stays, so updates remain blocked
        want_data = 1'b0;
        irq = 1'b0;
      end
      OP_IR: begin
        if (is_running && mode == MODE_IR && !unread) begin
          if (round_len == 8'h00) begin
            hit_cnt = 8'h00;
            pair_cnt = 8'h00;
            vote_flag = 1'b0;
          end else begin
            diff = (on_s >= off_s) ? on_s - off_s : off_s - on_s;
            if (diff >= thresh) hit_cnt = hit_cnt + 8'd1;
            pair_cnt = pair_cnt + 8'd1;
            if (pair_cnt >= round_len) begin
              // half the round or more must hit
              vote_flag = (2 * int'(hit_cnt) >= int'(round_len));
              hit_cnt = 8'h00;
              pair_cnt = 8'h00;
              ir_rounds++;
            end
          end
          sense_update();
        end
      end
      OP_TOUCH: begin
        if (is_running && mode == MODE_TOUCH && !unread) begin
          touched = tbits;
          sense_update();
        end
      end
      default: ;
    endcase
    r.trigger_line       = irq;
    r.run_mode           = mode;
    r.started            = is_running;
    r.touch_analog_gain  = a_gain;
    r.touch_digital_gain = d_gain;
    r.touch_filter_level = filt;
    r.ir_delay_ms        = pause_ms;
    return r;
  endfunction

  task automatic report_error(input string what);
    if (mismatches < 50) $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got_v,
                             input int unsigned want_v);
    if (got_v != want_v)
      report_error($sformatf("result %0d: %s is %0d, expected %0d",
                             results_seen, name, got_v, want_v));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      plate_reset();
      pending_results.delete();
      mismatches    = 0;
      outstanding   = 0;
      results_seen  = 0;
      sense_changes = 0;
      ir_rounds     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.read_data          = out_read_data;
        got.trigger_line       = out_trigger_line;
        got.run_mode           = out_run_mode;
        got.started            = out_started;
        got.touch_apply        = out_touch_apply;
        got.touch_recalibrate  = out_touch_recalibrate;
        got.reset_request      = out_reset_request;
        got.touch_analog_gain  = out_touch_analog_gain;
        got.touch_digital_gain = out_touch_digital_gain;
        got.touch_filter_level = out_touch_filter_level;
        got.ir_delay_ms        = out_ir_delay_ms;
        if (pending_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", 32'(got.read_data), 32'(want.read_data));
          check_field("trigger_line", 32'(got.trigger_line), 32'(want.trigger_line));
          check_field("run_mode", 32'(got.run_mode), 32'(want.run_mode));
          check_field("started", 32'(got.started), 32'(want.started));
          check_field("touch_apply", 32'(got.touch_apply), 32'(want.touch_apply));
          check_field("touch_recalibrate", 32'(got.touch_recalibrate),
                      32'(want.touch_recalibrate));
          check_field("reset_request", 32'(got.reset_request), 32'(want.reset_request));
          check_field("touch_analog_gain", 32'(got.touch_analog_gain),
                      32'(want.touch_analog_gain));
          check_field("touch_digital_gain", 32'(got.touch_digital_gain),
                      32'(want.touch_digital_gain));
          check_field("touch_filter_level", 32'(got.touch_filter_level),
                      32'(want.touch_filter_level));
          check_field("ir_delay_ms", 32'(got.ir_delay_ms), 32'(want.ir_delay_ms));
        end
        results_seen++;
      end
      if (in_valid && !in_stall)
        pending_results.push_back(plate_step(in_operation, in_bus_byte, in_ir_off_sample,
                                             in_ir_on_sample, in_touch_bits));
      outstanding = pending_results.size();
    end
  end

endmodule

### tb/sense_plate_command_and_ir_vote_tb.sv
// Top of the sense-plate command parser testbench: clock, reset, command and
// sensor stimulus under several idle and stall profiles, and the verdict.
// Depends on spcir_pkg, sense_plate_command_and_ir_vote and its checker.
`timescale 1ns / 100ps

module sense_plate_command_and_ir_vote_tb;
  import spcir_pkg::*;

  localparam int RAND_ITEMS  = 1400;
  localparam int SEGMENTS    = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [2:0]                    in_operation;
  logic [7:0]                    in_bus_byte;
  logic [SAMPLE_BITS_DEF-1:0]    in_ir_off_sample;
  logic [SAMPLE_BITS_DEF-1:0]    in_ir_on_sample;
  logic [TOUCH_CHANNELS_DEF-1:0] in_touch_bits;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [SENSE_W-1:0]            out_read_data;
  logic                          out_trigger_line;
  logic [1:0]                    out_run_mode;
  logic                          out_started;
  logic                          out_touch_apply;
  logic                          out_touch_recalibrate;
  logic                          out_reset_request;
  logic [7:0]                    out_touch_analog_gain;
  logic [7:0]                    out_touch_digital_gain;
  logic [7:0]                    out_touch_filter_level;
  logic [7:0]                    out_ir_delay_ms;

  int mismatches;
  int outstanding;
  int results_seen;
  int sense_changes;
  int ir_rounds;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  sense_plate_command_and_ir_vote uut (.*);

  sense_plate_command_and_ir_vote_checker chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sense_plate_command_and_ir_vote_tb: FAIL");
      $finish;
    end
  end

  // called and returns at a falling edge; holds the item until its transfer
  task automatic send_item(input logic [2:0] op, input logic [7:0] bv,
                           input logic [SAMPLE_BITS_DEF-1:0] off_s,
                           input logic [SAMPLE_BITS_DEF-1:0] on_s,
                           input logic [2:0] tbits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_bus_byte      <= bv;
    in_ir_off_sample <= off_s;
    in_ir_on_sample  <= on_s;
    in_touch_bits    <= tbits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // operation with every other field random
  task automatic send_op(input logic [2:0] op);
    send_item(op, 8'($urandom), SAMPLE_BITS_DEF'($urandom), SAMPLE_BITS_DEF'($urandom),
              3'($urandom));
  endtask

  task automatic bus_write(input logic [7:0] bv);
    send_item(OP_WRITE, bv, SAMPLE_BITS_DEF'($urandom), SAMPLE_BITS_DEF'($urandom),
              3'($urandom));
  endtask

  // off/on pair whose difference mostly lands near typical thresholds
  task automatic ir_pair();
    logic [SAMPLE_BITS_DEF-1:0] a;
    logic [SAMPLE_BITS_DEF-1:0] b;
    int x;
    a = SAMPLE_BITS_DEF'($urandom);
    case ($urandom_range(9))
      0: begin a = '0; b = '1; end
      1: begin a = '1; b = '0; end
      2: b = SAMPLE_BITS_DEF'($urandom);
      default: begin
        x = int'(a) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(40));
        if (x < 0) x = 0;
        if (x > 1023) x = 1023;
        b = SAMPLE_BITS_DEF'(x);
      end
    endcase
    send_item(OP_IR, 8'($urandom), a, b, 3'($urandom));
  endtask

  task automatic setting_pair();
    logic [7:0] cmd;
    logic [7:0] val;
    case ($urandom_range(5))
      0: cmd = CMD_SET_THRESH;
      1: cmd = CMD_SET_ROUND;
      2: cmd = CMD_SET_DELAY;
      3: cmd = CMD_SET_AGAIN;
      4: cmd = CMD_SET_DGAIN;
      default: cmd = CMD_SET_FILTER;
    endcase
    val = 8'($urandom);
    if (cmd == CMD_SET_THRESH && $urandom_range(9) < 8) val = 8'($urandom_range(40));
    // mostly short rounds so that votes complete often
    if (cmd == CMD_SET_ROUND && $urandom_range(19) != 0) val = 8'($urandom_range(8));
    bus_write(cmd);
    bus_write(val);
  endtask

  task automatic random_sequence();
    int kind;
    int n;
    int r;
    kind = $urandom_range(99);
    if (kind < 18) begin
      setting_pair();
    end else if (kind < 50) begin
      if ($urandom_range(4) != 0) bus_write(CMD_START);
      if ($urandom_range(4) != 0) bus_write(CMD_MODE_IR);
      if ($urandom_range(3) == 0) setting_pair();
      n = $urandom_range(4, 20);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 68) ir_pair();
        else if (r < 92) send_op(OP_READ);
        else if (r < 96) send_op(OP_TOUCH);
        else send_op(OP_ERROR);
      end
    end else if (kind < 75) begin
      if ($urandom_range(4) != 0) bus_write(CMD_START);
      if ($urandom_range(4) != 0) bus_write(CMD_MODE_TOUCH);
      n = $urandom_range(4, 16);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 60) send_op(OP_TOUCH);
        else if (r < 88) send_op(OP_READ);
        else if (r < 94) ir_pair();
        else send_op(OP_ERROR);
      end
    end else if (kind < 81) begin
      // setting command cut off by a stop or an error
      bus_write(CMD_SET_THRESH + 8'($urandom_range(2)));
      send_op($urandom_range(1) ? OP_STOP : OP_ERROR);
      bus_write(8'($urandom));
    end else if (kind < 84) begin
      bus_write(CMD_RESET);
    end else if (kind < 88) begin
      bus_write($urandom_range(1) ? CMD_RECAL_TOUCH : CMD_RECAL_TOUCH + 8'h01);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_op(3'($urandom_range(7)));
    end
  endtask

  initial begin
    int seg;
    int base;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_WRITE;
    in_bus_byte      = '0;
    in_ir_off_sample = '0;
    in_ir_on_sample  = '0;
    in_touch_bits    = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: setting writes (some at their extremes), each command, each corner
    send_op(OP_READ);
    bus_write(CMD_SET_AGAIN);
    bus_write(8'hFF);
    bus_write(CMD_SET_DGAIN);
    bus_write(8'h00);
    bus_write(CMD_SET_FILTER);
    bus_write(8'h5A);
    bus_write(CMD_SET_DELAY);
    bus_write(8'hA5);
    bus_write(CMD_SET_THRESH);
    send_op(OP_STOP);
    bus_write(8'hFF);
    bus_write(CMD_RECAL_TOUCH);
    bus_write(CMD_RECAL_TOUCH + 8'h01);
    send_item(OP_IR, 8'h00, '0, '1, 3'b000);
    bus_write(CMD_START);
    bus_write(CMD_MODE_IR);
    bus_write(CMD_SET_ROUND);
    bus_write(8'h00);
    send_item(OP_IR, 8'hFF, '1, '0, 3'b111);
    bus_write(CMD_MODE_TOUCH);
    send_item(OP_TOUCH, 8'h00, '0, '0, 3'b111);
    send_item(OP_TOUCH, 8'h00, '0, '0, 3'b000);
    send_op(OP_ERROR);
    send_op(OP_READ);
    send_op(3'd6);
    send_op(3'd7);
    bus_write(CMD_RESET);

    base = items_sent;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      while (items_sent < base + (seg + 1) * RAND_ITEMS / SEGMENTS) random_sequence();
      // let the result side run dry before the next profile
      in_valid <= 1'b0;
      @(negedge clk);
      while (outstanding != 0) @(negedge clk);
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d items under four idle/stall profiles; %0d results compared.",
             items_sent, results_seen);
    $display("Sense state changed %0d times, %0d IR vote rounds completed.",
             sense_changes, ir_rounds);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sense_plate_command_and_ir_vote_tb: PASS");
    end else begin
      $display("sense_plate_command_and_ir_vote_tb: FAIL");
    end
    $finish;
  end

endmodule
